FILE: hw/rtl/spe_pkg.sv
// Shared types and constants for the sinusoidal positional encoding adder.
// Holds the item structs, the cell bus struct and the fixed-point constants.
// No dependencies; every other file in hw/rtl imports this package.
package spe_pkg;

  // Field widths of the items
  localparam int unsigned EMB_W = 16;
  localparam int unsigned POS_W = 12;
  localparam int unsigned DIM_W = 4;
  localparam int unsigned PE_W  = 14;

  // Internal datapath widths
  localparam int unsigned PHASE_W = 32;
  localparam int unsigned RATE_W  = 32;
  localparam int unsigned MAG_W   = 31;
  localparam int unsigned X_W     = 31;
  localparam int unsigned U_W     = 32;
  localparam int unsigned T_W     = 31;
  localparam int unsigned CAP_W   = 13;
  localparam int unsigned SUM_W   = EMB_W + 1;
  localparam int unsigned RECIP_W = U_W + 1;

  // One rate per sine/cosine pair
  localparam int unsigned NUM_PAIRS = 2 ** (DIM_W - 1);

  // Fixed-point constants
  localparam logic [63:0] LOG2_TENK_Q32 = 64'd57070290109;
  localparam logic [63:0] LN2_Q32       = 64'd2977044472;
  localparam logic [63:0] INV2PI_Q32    = 64'd683565276;
  localparam logic [63:0] TWOPI_Q30     = 64'd6746518852;
  localparam logic [63:0] ONE_Q31       = 64'd2147483648;
  localparam int unsigned SERIES_TERMS  = 16;
  localparam int unsigned Q30_SHIFT     = 30;
  localparam int unsigned ROUND_SHIFT   = 18;

  localparam logic [T_W-1:0]     ONE_Q30      = T_W'(32'h4000_0000);
  localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [PHASE_W-1:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [U_W:0]       FULL_TURN    = 33'h1_0000_0000;
  localparam logic [U_W-1:0]     ROUND_BIAS   = 32'h0002_0000;
  localparam logic [CAP_W-1:0]   PE_MAX       = 13'd4096;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 17'sd32767;
  localparam logic signed [SUM_W-1:0] SUM_MIN = -17'sd32768;

  // Horner chain divisors, innermost first
  localparam int unsigned HORNER_STEPS = 5;
  localparam int unsigned HORNER_DIV [HORNER_STEPS] = '{110, 72, 42, 20, 6};

  typedef logic [RATE_W-1:0] rate_lut_t [NUM_PAIRS];

  typedef struct packed {
    logic signed [EMB_W-1:0] embed_value;
    logic [POS_W-1:0]        position;
    logic [DIM_W-1:0]        dim_index;
  } in_item_t;

  typedef struct packed {
    logic signed [PE_W-1:0]  pe_value;
    logic signed [EMB_W-1:0] sum_value;
    logic                    saturated;
  } out_item_t;

  // Data handed from cell to cell along the sine chain
  typedef struct packed {
    logic                    valid;
    logic [U_W-1:0]          u;
    logic [T_W-1:0]          t;
    logic [X_W-1:0]          x;
    logic                    neg;
    logic signed [EMB_W-1:0] emb;
  } horner_bus_t;

endpackage

FILE: hw/rtl/spe_front.sv
// Front end: rate lookup, phase multiply, quadrant fold and angle square.
// Three register stages feeding the sine cell chain. Depends on spe_pkg.
module spe_front #(
  parameter int unsigned MODEL_DIM = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  spe_pkg::in_item_t   in_item,
  output spe_pkg::horner_bus_t bus_out
);
  import spe_pkg::*;

  // Build turns-per-position for each pair at elaboration
  function automatic rate_lut_t build_rates();
    rate_lut_t   lut;
    logic [63:0] e;
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] plus;
    logic [63:0] minus;
    logic [63:0] r;
    for (int k = 0; k < NUM_PAIRS; k++) begin
      e     = (64'(2 * k) * LOG2_TENK_Q32) / 64'(MODEL_DIM);
      n     = e >> 32;
      f     = e & 64'hFFFF_FFFF;
      y     = (f * LN2_Q32) >> 33;
      term  = ONE_Q31;
      plus  = ONE_Q31;
      minus = 64'd0;
      for (int m = 1; m <= SERIES_TERMS; m++) begin
        term = ((term * y) >> 31) / 64'(m);
        if (m[0]) begin
          minus = minus + term;
        end else begin
          plus = plus + term;
        end
      end
      r = plus - minus;
      if (n >= 64'd33) begin
        lut[k] = '0;
      end else begin
        lut[k] = RATE_W'((r * INV2PI_Q32) >> (64'd31 + n));
      end
    end
    return lut;
  endfunction

  localparam rate_lut_t RATE_LUT = build_rates();

  // Stage 1: phase = position * rate, quarter turn added for cosine
  logic [POS_W+RATE_W-1:0] phase_prod;
  logic [PHASE_W-1:0]      phase_nxt;
  logic [PHASE_W-1:0]      phase_r;
  logic signed [EMB_W-1:0] emb1_r;
  logic                    valid1_r;

  always_comb begin
    phase_prod = (POS_W+RATE_W)'(in_item.position) *
                 (POS_W+RATE_W)'(RATE_LUT[in_item.dim_index[DIM_W-1:1]]);
    phase_nxt  = phase_prod[PHASE_W-1:0] + (in_item.dim_index[0] ? QUARTER_TURN : '0);
  end

  // Stage 2: fold into a quarter turn and scale to radians
  logic [PHASE_W-1:0]  quad;
  logic                flip;
  logic [PHASE_W-1:0]  folded;
  logic [MAG_W-1:0]    mag;
  logic                neg_nxt;
  logic [63:0]         x_prod;
  logic [X_W-1:0]      x_nxt;
  logic [X_W-1:0]      x2_r;
  logic                neg2_r;
  logic signed [EMB_W-1:0] emb2_r;
  logic                valid2_r;

  always_comb begin
    quad   = phase_r + QUARTER_TURN;
    flip   = quad[PHASE_W-1];
    folded = flip ? (phase_r ^ HALF_TURN) : phase_r;
    if (folded[PHASE_W-1]) begin
      neg_nxt = ~flip;
      mag     = MAG_W'(FULL_TURN - {1'b0, folded});
    end else begin
      neg_nxt = flip;
      mag     = MAG_W'(folded);
    end
    x_prod = 64'(mag) * TWOPI_Q30;
    x_nxt  = X_W'(x_prod >> 32);
  end

  // Stage 3: square of the angle
  logic [2*X_W-1:0] u_prod;
  logic [U_W-1:0]   u_nxt;
  logic [U_W-1:0]   u3_r;
  logic [X_W-1:0]   x3_r;
  logic             neg3_r;
  logic signed [EMB_W-1:0] emb3_r;
  logic             valid3_r;

  always_comb begin
    u_prod = (2*X_W)'(x2_r) * (2*X_W)'(x2_r);
    u_nxt  = U_W'(u_prod >> Q30_SHIFT);
  end

  // Advance the valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
      valid3_r <= 1'b0;
    end else begin
      valid1_r <= take;
      valid2_r <= valid1_r;
      valid3_r <= valid2_r;
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    phase_r <= phase_nxt;
    emb1_r  <= in_item.embed_value;
    x2_r    <= x_nxt;
    neg2_r  <= neg_nxt;
    emb2_r  <= emb1_r;
    u3_r    <= u_nxt;
    x3_r    <= x2_r;
    neg3_r  <= neg2_r;
    emb3_r  <= emb2_r;
  end

  assign bus_out.valid = valid3_r;
  assign bus_out.u     = u3_r;
  assign bus_out.t     = ONE_Q30;
  assign bus_out.x     = x3_r;
  assign bus_out.neg   = neg3_r;
  assign bus_out.emb   = emb3_r;

endmodule

FILE: hw/rtl/spe_horner_cell.sv
// One Horner step of the sine series: t <= 1 - (u * t) / DIV, two stages.
// Cells are chained; each passes the angle data on to its neighbor. Depends on spe_pkg.
module spe_horner_cell #(
  parameter int unsigned DIV = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  spe_pkg::horner_bus_t bus_in,
  output spe_pkg::horner_bus_t bus_out
);
  import spe_pkg::*;

  // Exact reciprocal for any 32-bit dividend
  localparam int unsigned SH = $clog2(DIV);
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((65'd1 << (U_W + SH)) + 65'(DIV) - 65'd1) / 65'(DIV));

  // Stage A: scaled product u * t
  logic [U_W+T_W-1:0] ut_prod;
  logic [U_W-1:0]     prod_nxt;
  logic [U_W-1:0]     prod_r;
  logic [U_W-1:0]     ua_r;
  logic [X_W-1:0]     xa_r;
  logic               nega_r;
  logic signed [EMB_W-1:0] emba_r;
  logic               valida_r;

  always_comb begin
    ut_prod  = (U_W+T_W)'(bus_in.u) * (U_W+T_W)'(bus_in.t);
    prod_nxt = U_W'(ut_prod >> Q30_SHIFT);
  end

  // Stage B: divide by the step constant and subtract from one
  logic [U_W+RECIP_W-1:0] q_prod;
  logic [T_W-1:0]         q;
  logic [T_W-1:0]         t_nxt;
  logic [T_W-1:0]         t_r;
  logic [U_W-1:0]         ub_r;
  logic [X_W-1:0]         xb_r;
  logic                   negb_r;
  logic signed [EMB_W-1:0] embb_r;
  logic                   validb_r;

  always_comb begin
    q_prod = (U_W+RECIP_W)'(prod_r) * (U_W+RECIP_W)'(RECIP);
    q      = T_W'(q_prod >> (U_W + SH));
    t_nxt  = ONE_Q30 - q;
  end

  // Advance the valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valida_r <= 1'b0;
      validb_r <= 1'b0;
    end else begin
      valida_r <= bus_in.valid;
      validb_r <= valida_r;
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    ua_r   <= bus_in.u;
    xa_r   <= bus_in.x;
    nega_r <= bus_in.neg;
    emba_r <= bus_in.emb;
    t_r    <= t_nxt;
    ub_r   <= ua_r;
    xb_r   <= xa_r;
    negb_r <= nega_r;
    embb_r <= emba_r;
  end

  assign bus_out.valid = validb_r;
  assign bus_out.u     = ub_r;
  assign bus_out.t     = t_r;
  assign bus_out.x     = xb_r;
  assign bus_out.neg   = negb_r;
  assign bus_out.emb   = embb_r;

endmodule

FILE: hw/rtl/spe_back.sv
// Back end: final x * t, round to Q12, sign, and saturating add of the element.
// Two register stages ending in the result register. Depends on spe_pkg.
module spe_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  spe_pkg::horner_bus_t bus_in,
  output logic                 out_valid,
  output spe_pkg::out_item_t   out_item
);
  import spe_pkg::*;

  // Stage 1: sine magnitude in Q30
  logic [X_W+T_W-1:0] xt_prod;
  logic [X_W-1:0]     sin_nxt;
  logic [X_W-1:0]     sin_r;
  logic               neg_r;
  logic signed [EMB_W-1:0] emb_r;
  logic               valid1_r;

  always_comb begin
    xt_prod = (X_W+T_W)'(bus_in.x) * (X_W+T_W)'(bus_in.t);
    sin_nxt = X_W'(xt_prod >> Q30_SHIFT);
  end

  // Stage 2: round, cap, sign, then add and clip
  logic [U_W-1:0]          rnd_wide;
  logic [PE_W-1:0]         rnd;
  logic [CAP_W-1:0]        cap;
  logic signed [PE_W-1:0]  mag;
  logic signed [PE_W-1:0]  pe_nxt;
  logic signed [SUM_W-1:0] sum_wide;
  out_item_t               item_nxt;
  out_item_t               out_item_r;
  logic                    out_valid_r;

  always_comb begin
    rnd_wide = (U_W'(sin_r) + ROUND_BIAS) >> ROUND_SHIFT;
    rnd      = PE_W'(rnd_wide);
    cap      = (rnd > PE_W'(PE_MAX)) ? PE_MAX : CAP_W'(rnd);
    mag      = $signed({1'b0, cap});
    pe_nxt   = neg_r ? -mag : mag;
    sum_wide = SUM_W'(emb_r) + SUM_W'(pe_nxt);
    item_nxt.pe_value = pe_nxt;
    if (sum_wide > SUM_MAX) begin
      item_nxt.sum_value = EMB_W'(SUM_MAX);
      item_nxt.saturated = 1'b1;
    end else if (sum_wide < SUM_MIN) begin
      item_nxt.sum_value = EMB_W'(SUM_MIN);
      item_nxt.saturated = 1'b1;
    end else begin
      item_nxt.sum_value = EMB_W'(sum_wide);
      item_nxt.saturated = 1'b0;
    end
  end

  // Advance the valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      valid1_r    <= bus_in.valid;
      out_valid_r <= valid1_r;
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    sin_r      <= sin_nxt;
    neg_r      <= bus_in.neg;
    emb_r      <= bus_in.emb;
    out_item_r <= item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: hw/rtl/sinusoidal_position_encoding_add.sv
// Sinusoidal positional encoding adder: one item per cycle, fully pipelined.
// 15 register stages (3 front, 5 Horner cells of 2 each, 2 back) lie between the edge
// that takes an item and the result register that drives out_valid and out_item.
// Throughput one item a cycle; busy is high only while reset is held, never for results.
// Synchronous active-low reset clears every valid flag; no item is in flight after it.
module sinusoidal_position_encoding_add #(
  parameter int unsigned MODEL_DIM = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  spe_pkg::in_item_t  in_item,
  output logic               out_valid,
  output spe_pkg::out_item_t out_item
);
  import spe_pkg::*;

  horner_bus_t chain [HORNER_STEPS+1];
  logic        take;

  // Take an item in every cycle that start is high outside reset
  assign busy = ~rst_n;
  assign take = start & ~busy;

  spe_front #(
    .MODEL_DIM(MODEL_DIM)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .in_item(in_item),
    .bus_out(chain[0])
  );

  // Row of Horner cells, innermost term first
  for (genvar g = 0; g < HORNER_STEPS; g++) begin : g_cell
    spe_horner_cell #(
      .DIV(HORNER_DIV[g])
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .bus_in (chain[g]),
      .bus_out(chain[g+1])
    );
  end

  spe_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .bus_in   (chain[HORNER_STEPS]),
    .out_valid(out_valid),
    .out_item (out_item)
  );

endmodule

FILE: hw/rtl/spe_checker.sv
// Port-level checks for the positional encoding adder, bound to the top level.
// Depends on spe_pkg and sinusoidal_position_encoding_add.
module spe_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input spe_pkg::in_item_t  in_item,
  input logic               out_valid,
  input spe_pkg::out_item_t out_item
);
  import spe_pkg::*;

  // Every taken item comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##15 out_valid)
    else $error("item taken without a result after fixed latency");

  // No result appears without an item taken at the fixed distance
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 15))
    else $error("result without a matching item");

  // Encoding stays within plus or minus one
  a_pe_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.pe_value <= 14'sd4096 && out_item.pe_value >= -14'sd4096))
    else $error("encoding value out of range");

  // Unclipped sum equals the element of the matching item plus the encoding
  a_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.saturated) |->
      (SUM_W'(out_item.sum_value) ==
       SUM_W'($past(in_item.embed_value, 15)) + SUM_W'(out_item.pe_value)))
    else $error("sum does not match element plus encoding");

  // A clipped sum sits at a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.saturated) |->
      (out_item.sum_value == 16'sh7fff || out_item.sum_value == -16'sh8000))
    else $error("clipped sum not at a rail");

endmodule

bind sinusoidal_position_encoding_add spe_checker u_spe_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_item  (in_item),
  .out_valid(out_valid),
  .out_item (out_item)
);
